// ===== src/rdpc_pkg.sv =====
// Shared constants and types for the Rand distance pair counter.
`default_nettype none

package rdpc_pkg;

    // Label and table sizing
    localparam int LABEL_W      = 5;
    localparam int N_LABELS     = 16;
    localparam int IDX_W        = $clog2(N_LABELS);
    localparam int JOINT_DEPTH  = N_LABELS * N_LABELS;
    localparam int JIDX_W       = $clog2(JOINT_DEPTH);

    // Element limit and counter widths
    localparam int MAX_ELEMENTS = 4096;
    localparam int CNT_W        = 13;
    localparam int DIST_W       = 23;

    // Stream widths
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 40;

    // One finished result
    typedef struct packed {
        logic              overflow;
        logic [CNT_W-1:0]  element_total;
        logic [DIST_W-1:0] distance;
    } t_result;

endpackage

`default_nettype wire

// ===== src/rand_distance_pair_counter.sv =====
// Rand distance pair counter: one element per transaction, distance out on the last one.
//
// Slave stream: each transaction is one element, its block label in the first
// partition (tdata[4:0]) and in the second (tdata[9:5]), labels 1..16; tlast
// marks the final element of a set. An element with a label out of range is
// skipped, and one beyond 4096 counted elements sets the overflow flag.
// Master stream: one transaction per set, issued for the tlast element:
// distance and element total in tdata, overflow in tuser.
// Throughput: one element per cycle, unless a last element waits on a full
// output. The joint-count RAM read is issued at acceptance and the
// read-modify-write completes when stage one advances, with the previous
// element's write forwarded. The tlast element reaches m_axis_tvalid through
// stage one and the output register. All tables clear together when a result
// is issued, so sets may follow each other without gaps. Reset empties the
// pipeline and all tables. When the master side stalls, the result is held in
// the output register; the pipeline keeps taking elements until a second
// result would have to wait, then drops s_axis_tready.
`default_nettype none

module rand_distance_pair_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // fields from bit 0: label_first[4:0], label_second[9:5], zero fill
    input  wire logic [rdpc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // fields from bit 0: distance[22:0], element_total[35:23], zero fill
    output logic [rdpc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // fields from bit 0: overflow
    output logic                               o_m_axis_tuser
);
    import rdpc_pkg::*;

    // Input decode
    logic [LABEL_W-1:0] in_la, in_lb;
    logic               in_ok;
    logic [IDX_W-1:0]   in_p, in_q;
    logic [JIDX_W-1:0]  in_j;
    logic [LABEL_W-1:0] la_m1, lb_m1;

    assign in_la = i_s_axis_tdata[LABEL_W-1:0];
    assign in_lb = i_s_axis_tdata[2*LABEL_W-1:LABEL_W];
    assign in_ok = (in_la != '0) && (in_la <= LABEL_W'(N_LABELS))
                && (in_lb != '0) && (in_lb <= LABEL_W'(N_LABELS));
    assign la_m1 = in_la - LABEL_W'(1);
    assign lb_m1 = in_lb - LABEL_W'(1);
    assign in_p  = la_m1[IDX_W-1:0];
    assign in_q  = lb_m1[IDX_W-1:0];
    assign in_j  = JIDX_W'(int'(in_p) * N_LABELS + int'(in_q));

    // Stage one registers
    logic               r_s1_valid, r_s1_last, r_s1_ok;
    logic [IDX_W-1:0]   r_s1_p, r_s1_q;
    logic [JIDX_W-1:0]  r_s1_j;
    logic               r_rd_valid, r_fwd_hit, r_fwd_clear;
    logic [CNT_W-1:0]   r_fwd_data;

    // Set state
    logic [CNT_W-1:0]   r_first_cnt  [N_LABELS];
    logic [CNT_W-1:0]   r_second_cnt [N_LABELS];
    logic [JOINT_DEPTH-1:0] r_jvalid;
    logic [DIST_W-1:0]  r_dist;
    logic [CNT_W-1:0]   r_elem_cnt;
    logic               r_ovf;

    logic               accept, s1_adv, out_can_load;
    logic [CNT_W-1:0]   rd_data, shared, fc, sc;
    logic               count_en, ovf_set, wr_en;
    logic [CNT_W-1:0]   wr_data;
    logic [CNT_W:0]     added;
    logic [DIST_W-1:0]  n_dist;
    logic [CNT_W-1:0]   n_elem_cnt;
    t_result            result;

    // Handshake: stage one moves unless a last element waits on a full output
    assign s1_adv          = r_s1_valid && (!r_s1_last || out_can_load);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Joint counts
    rdpc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (JOINT_DEPTH)
    ) u_joint_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_j),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (in_j),
        .o_rdata (rd_data)
    );

    // Pick the joint count: cleared, forwarded, stored or never written
    always_comb begin
        if (r_fwd_clear) begin
            shared = '0;
        end else if (r_fwd_hit) begin
            shared = r_fwd_data;
        end else if (r_rd_valid) begin
            shared = rd_data;
        end else begin
            shared = '0;
        end
    end

    // Count the new pairs that disagree
    assign fc         = r_first_cnt[r_s1_p];
    assign sc         = r_second_cnt[r_s1_q];
    assign count_en   = r_s1_ok && (r_elem_cnt < CNT_W'(MAX_ELEMENTS));
    assign ovf_set    = r_s1_ok && !(r_elem_cnt < CNT_W'(MAX_ELEMENTS));
    assign added      = {1'b0, fc - shared} + {1'b0, sc - shared};
    assign n_dist     = count_en ? r_dist + DIST_W'(added) : r_dist;
    assign n_elem_cnt = count_en ? r_elem_cnt + CNT_W'(1) : r_elem_cnt;
    assign wr_en      = s1_adv && count_en;
    assign wr_data    = shared + CNT_W'(1);

    assign result.distance      = n_dist;
    assign result.element_total = n_elem_cnt;
    assign result.overflow      = r_ovf || ovf_set;

    // Advance stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Load stage one payload and the forwarding snapshot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last   <= i_s_axis_tlast;
            r_s1_ok     <= in_ok;
            r_s1_p      <= in_p;
            r_s1_q      <= in_q;
            r_s1_j      <= in_j;
            r_rd_valid  <= r_jvalid[in_j];
            r_fwd_hit   <= wr_en && (r_s1_j == in_j);
            r_fwd_data  <= wr_data;
            r_fwd_clear <= s1_adv && r_s1_last;
        end
    end

    // Update or clear the set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_LABELS; i++) begin
                r_first_cnt[i]  <= '0;
                r_second_cnt[i] <= '0;
            end
            r_jvalid   <= '0;
            r_dist     <= '0;
            r_elem_cnt <= '0;
            r_ovf      <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                for (int i = 0; i < N_LABELS; i++) begin
                    r_first_cnt[i]  <= '0;
                    r_second_cnt[i] <= '0;
                end
                r_jvalid   <= '0;
                r_dist     <= '0;
                r_elem_cnt <= '0;
                r_ovf      <= 1'b0;
            end else begin
                if (count_en) begin
                    r_first_cnt[r_s1_p]  <= fc + CNT_W'(1);
                    r_second_cnt[r_s1_q] <= sc + CNT_W'(1);
                    r_jvalid[r_s1_j]     <= 1'b1;
                end
                r_dist     <= n_dist;
                r_elem_cnt <= n_elem_cnt;
                r_ovf      <= result.overflow;
            end
        end
    end

    // Result register
    rdpc_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_adv && r_s1_last),
        .i_result        (result),
        .o_can_load      (out_can_load),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== src/rdpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/rdpc_out_reg.sv =====
// Output register for result transactions on the master stream.
`default_nettype none

module rdpc_out_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire rdpc_pkg::t_result             i_result,
    output logic                               o_can_load,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // fields from bit 0: distance[22:0], element_total[35:23], zero fill
    output logic [rdpc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // fields from bit 0: overflow
    output logic                               o_m_axis_tuser
);
    import rdpc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_m_axis_tready;

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - CNT_W - DIST_W)'(0),
                              r_result.element_total, r_result.distance};
    assign o_m_axis_tuser  = r_result.overflow;

endmodule

`default_nettype wire
